### rtl/core/lkr_pkg.sv
// Shared sizes, result codes and structures of the line keyword recognizer.
package lkr_pkg;

	// Table geometry
	localparam int KEYWORD_COUNT   = 16;
	localparam int MAX_KEYWORD_LEN = 16;
	localparam int KW_IDX_W        = $clog2(KEYWORD_COUNT);
	localparam int POS_IDX_W       = $clog2(MAX_KEYWORD_LEN);
	localparam int POS_W           = $clog2(MAX_KEYWORD_LEN + 1);

	// Result kinds
	localparam logic [1:0] KIND_FOUND = 2'd0;
	localparam logic [1:0] KIND_NONE  = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	typedef struct packed {
		logic [7:0] comment_mark;
		logic [7:0] separator_char;
		logic [7:0] end_of_line_char;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [3:0]  keyword_number;
		logic [15:0] line_total;
		logic        last;
	} result_t;

	// Up to two result words pushed into the output queue together
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

### rtl/core/lkr_lane.sv
// One keyword row of the table with its compare against the current character.
module lkr_lane (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [lkr_pkg::POS_IDX_W-1:0] wr_pos,
	input  logic [7:0]                    wr_byte,
	input  logic [lkr_pkg::POS_W-1:0]     rd_pos,
	input  logic [7:0]                    text_char,
	output logic                          first_hit,
	output logic                          pos_hit
);
	import lkr_pkg::*;

	logic [7:0] row_q [MAX_KEYWORD_LEN];

	// Load one table byte
	always_ff @(posedge clk) begin
		if (wr_en) begin
			row_q[wr_pos] <= wr_byte;
		end
	end

	// Compare the opening byte and the byte at the match position
	assign first_hit = (row_q[0] == text_char);
	assign pos_hit   = (int'(rd_pos) < MAX_KEYWORD_LEN) &&
	                   (row_q[rd_pos[POS_IDX_W-1:0]] == text_char);

endmodule

### rtl/core/lkr_outq.sv
// Two-entry result queue that parts the scanner from the result channel.
module lkr_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  lkr_pkg::push_t   push,
	output logic [1:0]       room,
	input  logic             result_ready,
	output logic             result_valid,
	output lkr_pkg::result_t head
);
	import lkr_pkg::*;

	logic [1:0] cnt_q;
	result_t    e0_q;
	result_t    e1_q;
	logic       pop;
	logic [1:0] left;
	result_t    b0;

	assign result_valid = (cnt_q != 2'd0);
	assign pop          = result_valid && result_ready;
	assign left         = cnt_q - {1'b0, pop};
	assign room         = 2'd2 - left;
	assign b0           = pop ? e1_q : e0_q;
	assign head         = e0_q;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= left + push.count;
		end
	end

	// Advance the head and append new words behind what stays
	always_ff @(posedge clk) begin
		case (left)
			2'd0: begin
				e0_q <= push.first;
				e1_q <= push.second;
			end
			2'd1: begin
				e0_q <= b0;
				e1_q <= push.first;
			end
			default: begin
				e0_q <= b0;
				e1_q <= e1_q;
			end
		endcase
	end

endmodule

### rtl/core/lkr_scan.sv
// Input register, scan state and combinational recognition step.
module lkr_scan (
	input  logic           clk,
	input  logic           arst_n,
	input  lkr_pkg::cfg_t  cfg,
	input  logic           item_valid,
	output logic           item_ready,
	input  logic [1:0]     command,
	input  logic [7:0]     char_value,
	input  logic [3:0]     keyword_slot,
	input  logic [3:0]     char_position,
	input  logic [1:0]     room,
	output lkr_pkg::push_t push
);
	import lkr_pkg::*;

	localparam logic [1:0] CMD_TEXT  = 2'd0;
	localparam logic [1:0] CMD_END   = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	typedef enum logic [1:0] {
		PH_START,
		PH_SKIP,
		PH_COMMENT,
		PH_MATCH
	} phase_t;

	// Input register
	logic       valid_s1;
	logic [1:0] cmd_s1;
	logic [7:0] char_s1;
	logic [3:0] slot_s1;
	logic [3:0] cpos_s1;

	// Scan state
	phase_t                   phase_q;
	logic [KEYWORD_COUNT-1:0] mask_q;
	logic [POS_W-1:0]         pos_q;
	logic [15:0]              lines_q;

	// Next state and results
	phase_t                   phase_d;
	phase_t                   start_phase;
	logic [KEYWORD_COUNT-1:0] mask_d;
	logic [POS_W-1:0]         pos_d;
	logic [15:0]              lines_d;
	logic [1:0]               n_res;
	logic [1:0]               kind0;
	logic [KW_IDX_W-1:0]      num0;
	logic                     restart;

	logic [KEYWORD_COUNT-1:0] first_hits;
	logic [KEYWORD_COUNT-1:0] pos_hits;
	logic [KEYWORD_COUNT-1:0] hits;
	logic [KW_IDX_W-1:0]      found_num;
	logic                     found;
	logic                     is_sep;
	logic                     fire;
	logic                     table_wr;

	assign fire       = valid_s1 && (n_res <= room);
	assign item_ready = !valid_s1 || fire;
	assign table_wr   = fire && (cmd_s1 == CMD_WRITE) &&
	                    (int'(cpos_s1) < MAX_KEYWORD_LEN);

	// Keyword rows, all compared at once
	for (genvar k = 0; k < KEYWORD_COUNT; k++) begin : g_lane
		lkr_lane u_lane (
			.clk       (clk),
			.wr_en     (table_wr && (int'(slot_s1) == k)),
			.wr_pos    (POS_IDX_W'(cpos_s1)),
			.wr_byte   (char_s1),
			.rd_pos    (pos_q),
			.text_char (char_s1),
			.first_hit (first_hits[k]),
			.pos_hit   (pos_hits[k])
		);
	end

	assign is_sep = (char_s1 == cfg.separator_char);
	assign hits   = mask_q & pos_hits;
	assign found  = is_sep && (hits != '0);

	// Pick the lowest keyword that ends here
	always_comb begin
		found_num = '0;
		for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
			if (hits[k]) begin
				found_num = KW_IDX_W'(k);
			end
		end
	end

	// Recognition step for the item in the input register
	always_comb begin
		phase_d     = phase_q;
		mask_d      = mask_q;
		pos_d       = pos_q;
		lines_d     = lines_q;
		n_res       = 2'd0;
		kind0       = KIND_NONE;
		num0        = '0;
		restart     = 1'b0;
		start_phase = (phase_q == PH_MATCH) ? PH_START : phase_q;
		case (cmd_s1)
			CMD_END: begin
				phase_d = PH_START;
				mask_d  = '0;
				pos_d   = '0;
				n_res   = 2'd1;
				kind0   = KIND_END;
			end
			CMD_TEXT: begin
				case (phase_q)
					PH_COMMENT: begin
						if (char_s1 == cfg.end_of_line_char) begin
							lines_d = lines_q + 16'd1;
							phase_d = PH_START;
							mask_d  = '0;
							pos_d   = '0;
						end
					end
					PH_MATCH: begin
						if (found) begin
							n_res   = 2'd1;
							kind0   = KIND_FOUND;
							num0    = found_num;
							phase_d = PH_START;
							mask_d  = '0;
							pos_d   = '0;
						end else if (!is_sep && (hits != '0)) begin
							mask_d = hits;
							pos_d  = pos_q + POS_W'(1);
						end else begin
							n_res   = 2'd1;
							kind0   = KIND_NONE;
							restart = 1'b1;
						end
					end
					default: begin
						restart = 1'b1;
					end
				endcase
			end
			default: begin
			end
		endcase

		// Treat the character as the opening of a request
		if (restart) begin
			phase_d = PH_START;
			mask_d  = '0;
			pos_d   = '0;
			if ((start_phase == PH_START) && (char_s1 == cfg.comment_mark)) begin
				if (char_s1 == cfg.end_of_line_char) begin
					lines_d = lines_q + 16'd1;
				end else begin
					phase_d = PH_COMMENT;
				end
			end else if (is_sep) begin
				phase_d = PH_SKIP;
			end else if (first_hits == '0) begin
				if (n_res == 2'd0) begin
					kind0 = KIND_NONE;
				end
				n_res = n_res + 2'd1;
			end else begin
				mask_d  = first_hits;
				pos_d   = POS_W'(1);
				phase_d = PH_MATCH;
			end
		end
	end

	// Build the words for the result queue
	always_comb begin
		push.count  = fire ? n_res : 2'd0;
		push.first  = '{kind0, 4'(num0), lines_q, (n_res == 2'd1)};
		push.second = '{KIND_NONE, 4'd0, lines_q, 1'b1};
	end

	// Hold scan state and input register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= PH_START;
			mask_q   <= '0;
			pos_q    <= '0;
			lines_q  <= 16'd0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (fire) begin
				phase_q <= phase_d;
				mask_q  <= mask_d;
				pos_q   <= pos_d;
				lines_q <= lines_d;
			end
		end
	end

	// Capture an accepted word
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			cmd_s1  <= command;
			char_s1 <= char_value;
			slot_s1 <= keyword_slot;
			cpos_s1 <= char_position;
		end
	end

endmodule

### rtl/core/line_keyword_recognizer.sv
// Top level of the line keyword recognizer: register port, scanner and result queue.
//
// Use: text, end-of-input and table-load words enter on the item channel
// (item_valid/item_ready), one word per cycle while the input register can
// advance. Each word is held in an input register and handled there against all
// keyword rows at once; its results land in a two-entry result queue and leave
// on the result channel (result_valid/result_ready), one word per handshake.
// Throughput: one word per cycle while the result channel keeps up; a word
// that gives two results takes two handshakes on the result channel. The
// input register advances only when the queue has room for all results of
// its word, so a stalled receiver holds the queue and then the item channel,
// and nothing is lost.
// Configuration: comment, separator and end-of-line characters at byte
// addresses 0, 4 and 8 of the APB port, to be written by the user only while
// idle; the block itself does not enforce this.
// Reset: characters return to 35, 32 and 10, the scan returns to request
// start and the comment line count clears. Keyword table contents are not
// cleared and must be loaded before use; there is no clearing pass.
module line_keyword_recognizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  char_value,
	input  logic [3:0]  keyword_slot,
	input  logic [3:0]  char_position,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  result_kind,
	output logic [3:0]  keyword_number,
	output logic [15:0] line_total,
	output logic        last
);
	import lkr_pkg::*;

	localparam logic [1:0] REG_COMMENT     = 2'd0;
	localparam logic [1:0] REG_SEPARATOR   = 2'd1;
	localparam logic [1:0] REG_END_OF_LINE = 2'd2;

	cfg_t       cfg_q;
	push_t      push;
	logic [1:0] room;
	result_t    head;
	logic [1:0] reg_idx;

	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.comment_mark     <= 8'd35;
			cfg_q.separator_char   <= 8'd32;
			cfg_q.end_of_line_char <= 8'd10;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_COMMENT:     cfg_q.comment_mark     <= pwdata[7:0];
				REG_SEPARATOR:   cfg_q.separator_char   <= pwdata[7:0];
				REG_END_OF_LINE: cfg_q.end_of_line_char <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		case (reg_idx)
			REG_COMMENT:     prdata = {24'd0, cfg_q.comment_mark};
			REG_SEPARATOR:   prdata = {24'd0, cfg_q.separator_char};
			REG_END_OF_LINE: prdata = {24'd0, cfg_q.end_of_line_char};
			default:         prdata = 32'd0;
		endcase
	end

	lkr_scan u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.command       (command),
		.char_value    (char_value),
		.keyword_slot  (keyword_slot),
		.char_position (char_position),
		.room          (room),
		.push          (push)
	);

	lkr_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room         (room),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.head         (head)
	);

	assign result_kind    = head.result_kind;
	assign keyword_number = head.keyword_number;
	assign line_total     = head.line_total;
	assign last           = head.last;

	// Only a found keyword carries a number
	a_number_only_found: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result_kind != KIND_FOUND)) |-> (keyword_number == 4'd0))
		else $error("keyword number set on a result that is not a keyword");

	// End of input always closes the results of its word
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result_kind == KIND_END)) |-> last)
		else $error("end-of-input result not marked last");

	// The scanner never pushes more words than the queue can take
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.count <= room)
		else $error("result queue overrun");

endmodule

### tb/keyword_result_checker.sv
`timescale 1ns / 100ps
// Command codes, register addresses and the result checker for the line keyword recognizer bench.
package lkr_tb_pkg;

	// Item commands
	localparam logic [1:0] CMD_TEXT  = 2'd0;
	localparam logic [1:0] CMD_END   = 2'd1;
	localparam logic [1:0] CMD_LOAD  = 2'd2;
	localparam logic [1:0] CMD_SPARE = 2'd3;

	// Register byte addresses
	localparam logic [3:0] ADDR_COMMENT     = 4'd0;
	localparam logic [3:0] ADDR_SEPARATOR   = 4'd4;
	localparam logic [3:0] ADDR_END_OF_LINE = 4'd8;

endpackage

module keyword_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        item_valid,
	input  logic        item_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  char_value,
	input  logic [3:0]  keyword_slot,
	input  logic [3:0]  char_position,
	input  logic        result_valid,
	input  logic        result_ready,
	input  logic [1:0]  result_kind,
	input  logic [3:0]  keyword_number,
	input  logic [15:0] line_total,
	input  logic        last,
	output int          mismatch_count,
	output int          results_outstanding
);
	import lkr_pkg::*;
	import lkr_tb_pkg::*;

	localparam int REPORT_LIMIT = 10;

	typedef enum logic [1:0] {
		SCAN_START,
		SCAN_SKIP,
		SCAN_COMMENT,
		SCAN_MATCH
	} scan_phase_t;

	// Shadow of the recogniser state
	logic [7:0]               keyword_rows [KEYWORD_COUNT][MAX_KEYWORD_LEN];
	scan_phase_t              phase;
	logic [KEYWORD_COUNT-1:0] live_keywords;
	logic [POS_W-1:0]         match_pos;
	logic [15:0]              comment_lines;
	cfg_t                     chars;

	result_t word_results[$];
	result_t expected_results[$];
	result_t oldest_result;

	task automatic add_result(input logic [1:0] kind, input logic [3:0] num);
		result_t r;
		r.result_kind    = kind;
		r.keyword_number = num;
		r.line_total     = comment_lines;
		r.last           = 1'b0;
		word_results.push_back(r);
	endtask

	task automatic restart_scan();
		phase         = SCAN_START;
		live_keywords = '0;
		match_pos     = '0;
	endtask

	// First character of a request, or one after skipped separators
	task automatic open_request(input logic [7:0] c);
		logic [KEYWORD_COUNT-1:0] first_hits;
		first_hits = '0;
		if (phase == SCAN_START && c == chars.comment_mark) begin
			if (c == chars.end_of_line_char)
				comment_lines = comment_lines + 16'd1;
			else
				phase = SCAN_COMMENT;
		end else if (c == chars.separator_char) begin
			phase = SCAN_SKIP;
		end else begin
			for (int k = 0; k < KEYWORD_COUNT; k++)
				if (keyword_rows[k][0] == c)
					first_hits[k] = 1'b1;
			if (first_hits == '0) begin
				add_result(KIND_NONE, 4'd0);
				restart_scan();
			end else begin
				live_keywords = first_hits;
				match_pos     = POS_W'(1);
				phase         = SCAN_MATCH;
			end
		end
	endtask

	// Next character of a word: narrow the candidates, report on the separator
	task automatic extend_match(input logic [7:0] c);
		logic [KEYWORD_COUNT-1:0] still_live;
		int                       hit_idx;
		still_live = '0;
		hit_idx    = -1;
		if (match_pos < MAX_KEYWORD_LEN) begin
			for (int k = 0; k < KEYWORD_COUNT; k++) begin
				if (live_keywords[k] && keyword_rows[k][match_pos[POS_IDX_W-1:0]] == c) begin
					if (c == chars.separator_char) begin
						if (hit_idx < 0)
							hit_idx = k;
					end else begin
						still_live[k] = 1'b1;
					end
				end
			end
		end
		if (hit_idx >= 0) begin
			add_result(KIND_FOUND, hit_idx[3:0]);
			restart_scan();
		end else if (still_live != '0) begin
			live_keywords = still_live;
			match_pos     = match_pos + POS_W'(1);
		end else begin
			// all dropped out: the failing character opens the next request
			add_result(KIND_NONE, 4'd0);
			restart_scan();
			open_request(c);
		end
	endtask

	task automatic predict_word(input logic [1:0] cmd, input logic [7:0] c,
			input logic [3:0] slot, input logic [3:0] pos);
		result_t tail;
		word_results.delete();
		case (cmd)
			CMD_LOAD: begin
				if (slot < KEYWORD_COUNT && pos < MAX_KEYWORD_LEN)
					keyword_rows[slot][pos] = c;
			end
			CMD_END: begin
				restart_scan();
				add_result(KIND_END, 4'd0);
			end
			CMD_TEXT: begin
				if (phase == SCAN_COMMENT) begin
					if (c == chars.end_of_line_char) begin
						comment_lines = comment_lines + 16'd1;
						restart_scan();
					end
				end else if (phase == SCAN_MATCH) begin
					extend_match(c);
				end else begin
					open_request(c);
				end
			end
			default: ;
		endcase
		// mark the final result of this word
		if (word_results.size() > 0) begin
			tail      = word_results.pop_back();
			tail.last = 1'b1;
			word_results.push_back(tail);
		end
		foreach (word_results[i])
			expected_results.push_back(word_results[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_scan();
			comment_lines = '0;
			chars.comment_mark     = 8'd35;
			chars.separator_char   = 8'd32;
			chars.end_of_line_char = 8'd10;
			expected_results.delete();
			mismatch_count      = 0;
			results_outstanding = 0;
		end else begin
			// track register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					ADDR_COMMENT:     chars.comment_mark     = pwdata[7:0];
					ADDR_SEPARATOR:   chars.separator_char   = pwdata[7:0];
					ADDR_END_OF_LINE: chars.end_of_line_char = pwdata[7:0];
					default: ;
				endcase
			end
			// compare each result word with the oldest expectation
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("unexpected result word: kind %0d keyword %0d lines %0d last %0b",
							result_kind, keyword_number, line_total, last);
				end else begin
					oldest_result = expected_results.pop_front();
					if (result_kind !== oldest_result.result_kind ||
							keyword_number !== oldest_result.keyword_number ||
							line_total !== oldest_result.line_total ||
							last !== oldest_result.last) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT) begin
							$display("result mismatch: expected kind %0d keyword %0d lines %0d last %0b",
								oldest_result.result_kind, oldest_result.keyword_number,
								oldest_result.line_total, oldest_result.last);
							$display("                 got kind %0d keyword %0d lines %0d last %0b",
								result_kind, keyword_number, line_total, last);
						end
					end
				end
			end
			// predict the results of each accepted word
			if (item_valid && item_ready)
				predict_word(command, char_value, keyword_slot, char_position);
			results_outstanding = expected_results.size();
		end
	end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Top of the line keyword recognizer bench: clock, reset, stimulus and verdict.
module testbench;
	import lkr_pkg::*;
	import lkr_tb_pkg::*;

	localparam int RUN_LIMIT    = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RESET_CYCLES = 12;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        psel          = 1'b0;
	logic        penable       = 1'b0;
	logic        pwrite        = 1'b0;
	logic [3:0]  paddr         = '0;
	logic [31:0] pwdata        = '0;
	logic        item_valid    = 1'b0;
	logic [1:0]  command       = CMD_TEXT;
	logic [7:0]  char_value    = '0;
	logic [3:0]  keyword_slot  = '0;
	logic [3:0]  char_position = '0;
	logic        result_ready  = 1'b0;

	logic [31:0] prdata;
	logic        pready;
	logic        item_ready;
	logic        result_valid;
	logic [1:0]  result_kind;
	logic [3:0]  keyword_number;
	logic [15:0] line_total;
	logic        last;

	int mismatch_count;
	int results_outstanding;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int cycle_count    = 0;
	int word_count     = 0;

	// What the table holds, and the characters in force
	logic [7:0] kw_text [KEYWORD_COUNT][MAX_KEYWORD_LEN];
	logic [7:0] cur_comment = 8'd35;
	logic [7:0] cur_sep     = 8'd32;
	logic [7:0] cur_eol     = 8'd10;

	line_keyword_recognizer i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.command        (command),
		.char_value     (char_value),
		.keyword_slot   (keyword_slot),
		.char_position  (char_position),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.result_kind    (result_kind),
		.keyword_number (keyword_number),
		.line_total     (line_total),
		.last           (last)
	);

	keyword_result_checker i_checker (
		.clk                 (clk),
		.arst_n              (arst_n),
		.psel                (psel),
		.penable             (penable),
		.pwrite              (pwrite),
		.paddr               (paddr),
		.pwdata              (pwdata),
		.pready              (pready),
		.item_valid          (item_valid),
		.item_ready          (item_ready),
		.command             (command),
		.char_value          (char_value),
		.keyword_slot        (keyword_slot),
		.char_position       (char_position),
		.result_valid        (result_valid),
		.result_ready        (result_ready),
		.result_kind         (result_kind),
		.keyword_number      (keyword_number),
		.line_total          (line_total),
		.last                (last),
		.mismatch_count      (mismatch_count),
		.results_outstanding (results_outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Stall the result side at random
	always @(negedge clk)
		result_ready <= ($urandom_range(99) >= recv_stall_pct);

	// Offer one word and hold it until accepted; starts and ends at a falling edge
	task automatic send_word(input logic [1:0] cmd, input logic [7:0] c,
			input logic [3:0] slot, input logic [3:0] pos);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid    <= 1'b1;
		command       <= cmd;
		char_value    <= c;
		keyword_slot  <= slot;
		char_position <= pos;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
		if (cmd != CMD_SPARE)
			word_count++;
	endtask

	task automatic send_text(input logic [7:0] c);
		send_word(CMD_TEXT, c, 4'($urandom), 4'($urandom));
	endtask

	task automatic apb_write(input logic [3:0] addr, input logic [7:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {24'h0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_chars(input logic [7:0] com, input logic [7:0] sep,
			input logic [7:0] eol);
		apb_write(ADDR_COMMENT, com);
		apb_write(ADDR_SEPARATOR, sep);
		apb_write(ADDR_END_OF_LINE, eol);
		cur_comment = com;
		cur_sep     = sep;
		cur_eol     = eol;
	endtask

	// Drop valid, wait for every expected word, then let the pipeline empty
	task automatic settle();
		item_valid <= 1'b0;
		@(negedge clk);
		while (results_outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Letters from a small alphabet so that words share prefixes
	function automatic logic [7:0] pick_letter();
		logic [7:0] l;
		do l = 8'h61 + 8'($urandom_range(5)); while (l == cur_sep);
		return l;
	endfunction

	function automatic int keyword_length(input int k);
		int n;
		n = 0;
		while (n < MAX_KEYWORD_LEN && kw_text[k][n] != cur_sep)
			n++;
		return n;
	endfunction

	// Load each entry up to its separator; one entry without separator, one empty,
	// one duplicate
	task automatic load_table();
		int len;
		for (int s = 0; s < KEYWORD_COUNT; s++) begin
			if (s == KEYWORD_COUNT - 2)
				len = MAX_KEYWORD_LEN;
			else if (s == KEYWORD_COUNT - 1)
				len = 0;
			else if (s == KEYWORD_COUNT - 3)
				len = keyword_length(2);
			else if ($urandom_range(3) == 0)
				len = $urandom_range(7, MAX_KEYWORD_LEN - 1);
			else
				len = $urandom_range(1, 6);
			for (int p = 0; p < MAX_KEYWORD_LEN && p <= len; p++) begin
				if (s == KEYWORD_COUNT - 3)
					kw_text[s][p] = kw_text[2][p];
				else if (p < len)
					kw_text[s][p] = pick_letter();
				else
					kw_text[s][p] = cur_sep;
				send_word(CMD_LOAD, kw_text[s][p], 4'(s), 4'(p));
			end
		end
	endtask

	task automatic send_keyword(input int k);
		int n;
		n = keyword_length(k);
		for (int i = 0; i < n; i++)
			send_text(kw_text[k][i]);
		send_text(cur_sep);
	endtask

	// One random request, mostly well formed
	task automatic send_request();
		int         pick;
		int         k;
		int         n;
		logic [7:0] b;
		pick = $urandom_range(99);
		k    = $urandom_range(KEYWORD_COUNT - 1);
		if (pick < 48) begin
			repeat ($urandom_range(2)) send_text(cur_sep);
			send_keyword(k);
		end else if (pick < 60) begin
			// partial word, then a stray character
			n = $urandom_range(keyword_length(k));
			for (int i = 0; i < n; i++)
				send_text(kw_text[k][i]);
			send_text($urandom_range(1) ? pick_letter() : 8'($urandom));
		end else if (pick < 70) begin
			send_text(cur_comment);
			repeat ($urandom_range(4)) send_text(8'($urandom));
			send_text(cur_eol);
		end else if (pick < 76) begin
			send_word(CMD_END, 8'($urandom), 4'($urandom), 4'($urandom));
		end else if (pick < 85) begin
			send_text(8'($urandom));
		end else if (pick < 89) begin
			// overwrite one table byte ahead of the entry's end
			n = keyword_length(k);
			if (n > 0) begin
				n = $urandom_range(n - 1);
				b = $urandom_range(1) ? pick_letter() : 8'($urandom);
				kw_text[k][n] = b;
				send_word(CMD_LOAD, b, 4'(k), 4'(n));
			end
		end else if (pick < 91) begin
			send_word(CMD_SPARE, 8'($urandom), 4'($urandom), 4'($urandom));
		end else begin
			send_text(cur_sep);
		end
	endtask

	task automatic run_phase(input logic [7:0] com, input logic [7:0] sep,
			input logic [7:0] eol, input int sidle, input int rstall, input int words);
		settle();
		send_idle_pct  = sidle;
		recv_stall_pct = rstall;
		set_chars(com, sep, eol);
		load_table();
		word_count = 0;
		while (word_count < words)
			send_request();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// default characters, no idling, directed words first
		set_chars(8'd35, 8'd32, 8'd10);
		load_table();
		send_word(CMD_END, 8'h00, 4'h0, 4'h0);
		send_text(cur_comment);
		send_text(8'h78);
		send_text(cur_eol);
		// comment character after a separator is an ordinary character
		send_text(cur_sep);
		send_text(cur_comment);
		// no first-character match
		send_text(8'h00);
		send_text(8'hFF);
		send_keyword(0);
		// duplicate entry: the lower number wins
		send_keyword(KEYWORD_COUNT - 3);
		// drop out on the comment character, which then opens a comment
		send_text(kw_text[1][0]);
		send_text(cur_comment);
		send_text(cur_eol);
		// end of input in the middle of a word
		send_text(kw_text[4][0]);
		send_word(CMD_END, 8'hFF, 4'hF, 4'hF);
		send_word(CMD_SPARE, 8'hFF, 4'hF, 4'hF);
		kw_text[KEYWORD_COUNT - 1][MAX_KEYWORD_LEN - 1] = 8'h5A;
		send_word(CMD_LOAD, kw_text[KEYWORD_COUNT - 1][MAX_KEYWORD_LEN - 1], 4'hF, 4'hF);
		word_count = 0;
		while (word_count < 80)
			send_request();

		run_phase(8'h00, 8'hFF, 8'hFF, 64, 0, 80);
		run_phase(8'hFF, 8'h00, 8'h00, 0, 64, 80);
		// comment and end-of-line characters equal
		run_phase(8'h0A, 8'h20, 8'h0A, 11, 11, 80);
		run_phase(8'($urandom), 8'($urandom), 8'($urandom), 0, 0, 80);

		settle();
		if (mismatch_count == 0 && results_outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### filelist.f
rtl/core/lkr_pkg.sv
rtl/core/lkr_lane.sv
rtl/core/lkr_outq.sv
rtl/core/lkr_scan.sv
rtl/core/line_keyword_recognizer.sv
tb/keyword_result_checker.sv
tb/testbench.sv
